// ===== src/supervisor_init_sequencer_macros.svh =====
// Assertion macros shared by the supervisor init sequencer RTL.
// Depends on nothing; included by the top level for its checks.
`ifndef SUPERVISOR_INIT_SEQUENCER_MACROS_SVH
`define SUPERVISOR_INIT_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SVS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("supervisor_init_sequencer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SVS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("supervisor_init_sequencer: next-cycle check failed");

`endif

// ===== src/svs_pkg.sv =====
`timescale 1ns / 1ps
// Types, codes and constants of the supervisor init sequencer.
// Used by svs_cfg_regs, svs_core and supervisor_init_sequencer; depends on nothing.
package svs_pkg;

  localparam int MAX_RETRIES_DEF = 3;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int WAIT_W      = 16;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] CFG_WATCHDOG_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_WAIT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_WAIT       = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_IGNITION    = 2'd3;

  localparam logic [7:0] WATCHDOG_PERIOD_RST = 8'd10;
  localparam logic [7:0] SHORT_WAIT_RST      = 8'd1;
  localparam logic [7:0] LONG_WAIT_RST       = 8'd10;
  localparam logic       USE_IGNITION_RST    = 1'b1;

  // Operation selector and request kinds.
  localparam logic       OP_TICK     = 1'b0;
  localparam logic       OP_REQUEST  = 1'b1;
  localparam logic [1:0] KIND_INIT   = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;

  // Request status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ALREADY  = 2'd1;
  localparam logic [1:0] STATUS_ILLEGAL  = 2'd2;
  localparam logic [1:0] STATUS_PENDING  = 2'd3;

  // External check codes.
  localparam logic [2:0] CHK_NONE       = 3'd0;
  localparam logic [2:0] CHK_INIT_PHASE = 3'd1;
  localparam logic [2:0] CHK_REFRESHES  = 3'd2;
  localparam logic [2:0] CHK_FAULT_CNT  = 3'd3;
  localparam logic [2:0] CHK_SAFETY     = 3'd4;
  localparam logic [2:0] CHK_IGNITION   = 3'd5;

  // Reported machine state codes.
  localparam logic [1:0] MS_UNINIT = 2'd0;
  localparam logic [1:0] MS_INIT   = 2'd1;
  localparam logic [1:0] MS_RUN    = 2'd2;
  localparam logic [1:0] MS_ERR    = 2'd3;

  // Initialization phases.
  localparam logic [1:0] PH_ENTRY     = 2'd0;
  localparam logic [1:0] PH_REFRESHES = 2'd1;
  localparam logic [1:0] PH_FAULT_CNT = 2'd2;
  localparam logic [1:0] PH_SAFETY    = 2'd3;

  typedef enum logic [3:0] {
    ST_UNINIT = 4'b0001,
    ST_INIT   = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_ERR    = 4'b1000
  } main_state_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_INIT  = 2'd1,
    REQ_ERROR = 2'd2
  } pending_t;

  typedef struct packed {
    logic       operation;
    logic [1:0] request_kind;
    logic       check_ok;
    logic [7:0] required_refreshes;
    logic       refresh_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0] request_status;
    logic       watchdog_refresh;
    logic [2:0] check_performed;
    logic [1:0] machine_state;
    logic [1:0] init_phase;
    logic [7:0] illegal_requests;
  } result_t;

  typedef struct packed {
    logic [7:0] watchdog_period;
    logic [7:0] short_wait;
    logic [7:0] long_wait;
    logic       use_ignition;
  } cfg_t;

  function automatic logic [1:0] state_code(main_state_t st);
    logic [1:0] code;
    case (st)
      ST_UNINIT: code = MS_UNINIT;
      ST_INIT:   code = MS_INIT;
      ST_RUN:    code = MS_RUN;
      ST_ERR:    code = MS_ERR;
      default:   code = MS_UNINIT;
    endcase
    return code;
  endfunction

endpackage

// ===== src/svs_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file of the supervisor init sequencer.
// Depends on svs_pkg for register indexes, reset values and cfg_t.
module svs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [svs_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [svs_pkg::CFG_DATA_W-1:0]  wr_data,
  output svs_pkg::cfg_t                  cfg
);

  svs_pkg::cfg_t cfg_r;
  svs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        svs_pkg::CFG_WATCHDOG_PERIOD: cfg_nxt.watchdog_period = wr_data;
        svs_pkg::CFG_SHORT_WAIT:      cfg_nxt.short_wait      = wr_data;
        svs_pkg::CFG_LONG_WAIT:       cfg_nxt.long_wait       = wr_data;
        svs_pkg::CFG_USE_IGNITION:    cfg_nxt.use_ignition    = wr_data[0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.watchdog_period <= svs_pkg::WATCHDOG_PERIOD_RST;
      cfg_r.short_wait      <= svs_pkg::SHORT_WAIT_RST;
      cfg_r.long_wait       <= svs_pkg::LONG_WAIT_RST;
      cfg_r.use_ignition    <= svs_pkg::USE_IGNITION_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/svs_core.sv =====
`timescale 1ns / 1ps
// Sequencer state and the single-pass step logic for one request or tick.
// Depends on svs_pkg for state, item, result and configuration types.
module svs_core #(
  parameter int MAX_RETRIES = svs_pkg::MAX_RETRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  svs_pkg::in_item_t item,
  input  svs_pkg::cfg_t     cfg,
  output svs_pkg::result_t  result
);

  localparam int RW = $clog2(MAX_RETRIES + 1);
  localparam logic [RW:0] RETRY_LIMIT = (RW + 1)'(MAX_RETRIES);

  svs_pkg::main_state_t state_r, state_nxt;
  svs_pkg::pending_t    pending_r, pending_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [svs_pkg::WAIT_W-1:0] wait_r, wait_nxt;
  logic [7:0]           refresh_r, refresh_nxt;
  logic                 wd_active_r, wd_active_nxt;
  logic [RW-1:0]        retry_r, retry_nxt;
  logic [7:0]           illegal_r, illegal_nxt;

  logic [1:0]  status;
  logic        strobe;
  logic [2:0]  check;
  logic        run;
  logic [RW:0] retry_inc;
  logic        retry_over;
  logic [svs_pkg::WAIT_W-1:0] refresh_wait;
  logic [svs_pkg::WAIT_W-1:0] short_wait_w;

  assign retry_inc    = {1'b0, retry_r} + (RW + 1)'(1);
  assign retry_over   = retry_inc > RETRY_LIMIT;
  assign refresh_wait = svs_pkg::WAIT_W'(item.required_refreshes)
                      * svs_pkg::WAIT_W'(cfg.watchdog_period);
  assign short_wait_w = svs_pkg::WAIT_W'(cfg.short_wait);

  always_comb begin
    state_nxt     = state_r;
    pending_nxt   = pending_r;
    phase_nxt     = phase_r;
    wait_nxt      = wait_r;
    refresh_nxt   = refresh_r;
    wd_active_nxt = wd_active_r;
    retry_nxt     = retry_r;
    illegal_nxt   = illegal_r;
    status        = svs_pkg::STATUS_OK;
    strobe        = 1'b0;
    check         = svs_pkg::CHK_NONE;
    run           = 1'b1;

    if (item.operation == svs_pkg::OP_REQUEST) begin
      if (item.request_kind == svs_pkg::KIND_ERROR) begin
        status = svs_pkg::STATUS_OK;
      end else if (pending_r != svs_pkg::REQ_NONE) begin
        status = svs_pkg::STATUS_PENDING;
      end else if (item.request_kind == svs_pkg::KIND_INIT) begin
        status = (state_r == svs_pkg::ST_UNINIT) ? svs_pkg::STATUS_OK
                                                 : svs_pkg::STATUS_ALREADY;
      end else begin
        status = svs_pkg::STATUS_ILLEGAL;
      end
      if (status == svs_pkg::STATUS_OK) begin
        pending_nxt = (item.request_kind == svs_pkg::KIND_ERROR) ? svs_pkg::REQ_ERROR
                                                                 : svs_pkg::REQ_INIT;
      end
    end else begin
      // Periodic watchdog: the strobe fires when the counter reaches zero and
      // only a successful refresh reloads it.
      if (wd_active_r && (refresh_r != 8'd0)) begin
        refresh_nxt = refresh_r - 8'd1;
        if (refresh_nxt == 8'd0) begin
          strobe = 1'b1;
          if (item.refresh_ok) begin
            refresh_nxt = cfg.watchdog_period;
          end
        end
      end
      if (wait_r != '0) begin
        wait_nxt = wait_r - svs_pkg::WAIT_W'(1);
        run      = (wait_nxt == '0);
      end
      if (run) begin
        case (state_r)
          svs_pkg::ST_UNINIT: begin
            pending_nxt = svs_pkg::REQ_NONE;
            if (pending_r == svs_pkg::REQ_INIT) begin
              wait_nxt  = short_wait_w;
              state_nxt = svs_pkg::ST_INIT;
              phase_nxt = svs_pkg::PH_ENTRY;
            end else if (pending_r != svs_pkg::REQ_NONE) begin
              if (illegal_r != 8'hFF) begin
                illegal_nxt = illegal_r + 8'd1;
              end
            end
          end
          svs_pkg::ST_INIT: begin
            case (phase_r)
              svs_pkg::PH_ENTRY:     check = svs_pkg::CHK_INIT_PHASE;
              svs_pkg::PH_REFRESHES: check = svs_pkg::CHK_REFRESHES;
              svs_pkg::PH_FAULT_CNT: check = svs_pkg::CHK_FAULT_CNT;
              default:               check = svs_pkg::CHK_SAFETY;
            endcase
            if (!item.check_ok) begin
              // A failed phase is retried until the limit, then the machine
              // drops into the error state.
              if (retry_over) begin
                retry_nxt = '0;
                state_nxt = svs_pkg::ST_ERR;
                phase_nxt = svs_pkg::PH_ENTRY;
                wait_nxt  = short_wait_w;
              end else begin
                retry_nxt = retry_inc[RW-1:0];
              end
              if (phase_r == svs_pkg::PH_FAULT_CNT || phase_r == svs_pkg::PH_SAFETY) begin
                wait_nxt = short_wait_w;
              end
            end else begin
              case (phase_r)
                svs_pkg::PH_ENTRY: begin
                  wd_active_nxt = 1'b1;
                  refresh_nxt   = cfg.watchdog_period;
                  wait_nxt      = short_wait_w;
                  phase_nxt     = svs_pkg::PH_REFRESHES;
                  retry_nxt     = '0;
                end
                svs_pkg::PH_REFRESHES: begin
                  retry_nxt = '0;
                  wait_nxt  = refresh_wait;
                  phase_nxt = svs_pkg::PH_FAULT_CNT;
                end
                svs_pkg::PH_FAULT_CNT: begin
                  phase_nxt = svs_pkg::PH_SAFETY;
                  wait_nxt  = short_wait_w;
                end
                default: begin
                  retry_nxt = '0;
                  state_nxt = svs_pkg::ST_RUN;
                  phase_nxt = svs_pkg::PH_ENTRY;
                  wait_nxt  = short_wait_w;
                end
              endcase
            end
          end
          svs_pkg::ST_RUN: begin
            wait_nxt = svs_pkg::WAIT_W'(cfg.long_wait);
            if (cfg.use_ignition) begin
              check = svs_pkg::CHK_IGNITION;
            end
          end
          default: begin
            wait_nxt = svs_pkg::WAIT_W'(cfg.long_wait);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svs_pkg::ST_UNINIT;
      pending_r   <= svs_pkg::REQ_NONE;
      phase_r     <= svs_pkg::PH_ENTRY;
      wait_r      <= '0;
      refresh_r   <= '0;
      wd_active_r <= 1'b0;
      retry_r     <= '0;
      illegal_r   <= '0;
    end else if (step_en) begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      phase_r     <= phase_nxt;
      wait_r      <= wait_nxt;
      refresh_r   <= refresh_nxt;
      wd_active_r <= wd_active_nxt;
      retry_r     <= retry_nxt;
      illegal_r   <= illegal_nxt;
    end
  end

  always_comb begin
    result.request_status   = status;
    result.watchdog_refresh = strobe;
    result.check_performed  = check;
    result.machine_state    = svs_pkg::state_code(state_nxt);
    result.init_phase       = phase_nxt;
    result.illegal_requests = illegal_nxt;
  end

endmodule

// ===== src/supervisor_init_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the supervisor init sequencer: stream ports, pipeline registers, checks.
// Depends on svs_pkg, svs_cfg_regs, svs_core and supervisor_init_sequencer_macros.svh.
//
// Usage: each input beat is either a time tick or a state request, selected by
// in_tuser. Every accepted beat produces exactly one result beat on out_*.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high, and writes are meant to happen while the block is idle.
//
// An accepted input beat is held in the input register; the step logic then
// writes its result into the output register, which drives out_*. Throughput
// is one beat per cycle while the receiver does not stall; the step logic
// updates the sequencer state in a single pass, so a new beat may follow in
// every cycle.
//
// When the receiver stalls, the result stays in the output register and the
// input register can still take one more beat; in_tready drops only while both
// registers are full and out_tready is low. Reset (rst_n low, synchronous)
// empties both registers, returns the sequencer to uninitialized with no
// pending request, clears all counters and loads the configuration defaults.
`include "supervisor_init_sequencer_macros.svh"

module supervisor_init_sequencer #(
  parameter int MAX_RETRIES = svs_pkg::MAX_RETRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata from bit 0: request_kind[1:0], check_ok[2], required_refreshes[10:3],
  // refresh_ok[11], zero fill [15:12].
  input  logic [svs_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: operation[0].
  input  logic                              in_tuser,
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata from bit 0: request_status[1:0], watchdog_refresh[2],
  // check_performed[5:3], machine_state[7:6], init_phase[9:8],
  // illegal_requests[17:10], zero fill [23:18].
  output logic [svs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [svs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [svs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  svs_pkg::cfg_t     cfg;
  svs_pkg::in_item_t in_item_r, in_item_nxt;
  logic              in_valid_r, in_valid_nxt;
  svs_pkg::result_t  step_result;
  svs_pkg::result_t  out_item_r;
  logic              out_valid_r, out_valid_nxt;
  logic              advance;
  logic              in_beat;
  logic              req_step;
  logic              tick_fields_clear;
  logic              illegal_grows;

  assign cfg_ready = 1'b1;

  svs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held beat moves into the output register whenever that register is
  // empty or being drained in this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    in_item_nxt.operation          = in_tuser;
    in_item_nxt.request_kind       = in_tdata[1:0];
    in_item_nxt.check_ok           = in_tdata[2];
    in_item_nxt.required_refreshes = in_tdata[10:3];
    in_item_nxt.refresh_ok         = in_tdata[11];
    in_valid_nxt  = in_beat ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  svs_core #(
    .MAX_RETRIES (MAX_RETRIES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      in_item_r <= in_item_nxt;
    end
    if (advance) begin
      out_item_r <= step_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0,
                       out_item_r.illegal_requests,
                       out_item_r.init_phase,
                       out_item_r.machine_state,
                       out_item_r.check_performed,
                       out_item_r.watchdog_refresh,
                       out_item_r.request_status};

  assign req_step          = advance && (in_item_r.operation == svs_pkg::OP_REQUEST);
  assign tick_fields_clear = !step_result.watchdog_refresh
                           && (step_result.check_performed == svs_pkg::CHK_NONE);
  assign illegal_grows     = step_result.illegal_requests >= out_item_r.illegal_requests;

  // With both registers full and the receiver stalled, no new beat may enter.
  `SVS_ASSERT_IMP(a_full_blocks_input, clk, rst_n, in_valid_r && out_valid_r && !out_tready, !in_tready)
  // A request never issues a watchdog strobe or reports an external check.
  `SVS_ASSERT_IMP(a_request_no_tick_fields, clk, rst_n, req_step, tick_fields_clear)
  // The illegal request count only grows.
  `SVS_ASSERT_IMP(a_illegal_monotonic, clk, rst_n, out_valid_r, illegal_grows)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for supervisor_init_sequencer: a scoreboard class predicts
// every result beat from the accepted ticks and requests, and plain tasks drive the ports.
// Depends on svs_pkg and the supervisor_init_sequencer RTL.
module tb;

  // Request kinds that the package leaves unnamed; both are illegal requests.
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Shapes of the random stimulus. SATURATE keeps the sequencer uninitialized and
  // feeds it error requests, INIT_WALK takes it through initialization, and LATE
  // exercises the running or error state.
  typedef enum int {SATURATE, INIT_WALK, LATE} stim_mode_t;

  // Scoreboard: a cycle-free model of the sequencer plus the queue of results
  // that it has predicted and that the block still owes.
  class sequencer_scoreboard;
    logic [7:0]         wd_period;
    logic [7:0]         short_w;
    logic [7:0]         long_w;
    logic               ignition_chk;
    logic [1:0]         mstate;
    logic [1:0]         phase;
    logic [15:0]        wait_cnt;
    logic [7:0]         refresh_cnt;
    logic               wd_active;
    logic [2:0]         retries;
    svs_pkg::pending_t  pending;
    logic [7:0]         illegal;
    svs_pkg::result_t   expected_results[$];
    int                 capped_takes;
    int                 n_requests;
    int                 n_ticks;
    int                 n_strobes;
    int                 checked;
    int                 mismatches;

    function new();
      wd_period    = svs_pkg::WATCHDOG_PERIOD_RST;
      short_w      = svs_pkg::SHORT_WAIT_RST;
      long_w       = svs_pkg::LONG_WAIT_RST;
      ignition_chk = svs_pkg::USE_IGNITION_RST;
      mstate       = svs_pkg::MS_UNINIT;
      phase        = svs_pkg::PH_ENTRY;
      wait_cnt     = '0;
      refresh_cnt  = '0;
      wd_active    = 1'b0;
      retries      = '0;
      pending      = svs_pkg::REQ_NONE;
      illegal      = '0;
      capped_takes = 0;
      n_requests   = 0;
      n_ticks      = 0;
      n_strobes    = 0;
      checked      = 0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [svs_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] val);
      case (idx)
        svs_pkg::CFG_WATCHDOG_PERIOD: wd_period = val;
        svs_pkg::CFG_SHORT_WAIT:      short_w = val;
        svs_pkg::CFG_LONG_WAIT:       long_w = val;
        default:                      ignition_chk = val[0];
      endcase
    endfunction

    // Advances the model by one accepted beat and queues the result it causes.
    function void note_beat(svs_pkg::in_item_t b);
      svs_pkg::result_t r;
      logic             run;
      logic             gave_up;
      logic [1:0]       was_phase;
      r = '0;
      if (b.operation == svs_pkg::OP_REQUEST) begin
        n_requests++;
        if (b.request_kind == svs_pkg::KIND_ERROR) begin
          r.request_status = svs_pkg::STATUS_OK;
        end else if (pending != svs_pkg::REQ_NONE) begin
          r.request_status = svs_pkg::STATUS_PENDING;
        end else if (b.request_kind == svs_pkg::KIND_INIT) begin
          r.request_status = (mstate == svs_pkg::MS_UNINIT) ? svs_pkg::STATUS_OK
                                                             : svs_pkg::STATUS_ALREADY;
        end else begin
          r.request_status = svs_pkg::STATUS_ILLEGAL;
        end
        if (r.request_status == svs_pkg::STATUS_OK)
          pending = (b.request_kind == svs_pkg::KIND_ERROR) ? svs_pkg::REQ_ERROR
                                                             : svs_pkg::REQ_INIT;
      end else begin
        n_ticks++;
        run = 1'b1;
        // The watchdog runs first; a failed refresh leaves the counter at zero.
        if (wd_active && refresh_cnt != 0) begin
          refresh_cnt = refresh_cnt - 8'd1;
          if (refresh_cnt == 0) begin
            r.watchdog_refresh = 1'b1;
            n_strobes++;
            if (b.refresh_ok)
              refresh_cnt = wd_period;
          end
        end
        if (wait_cnt != 0) begin
          wait_cnt = wait_cnt - 16'd1;
          if (wait_cnt != 0)
            run = 1'b0;
        end
        if (run) begin
          case (mstate)
            svs_pkg::MS_UNINIT: begin
              if (pending == svs_pkg::REQ_INIT) begin
                wait_cnt = 16'(short_w);
                mstate = svs_pkg::MS_INIT;
                phase = svs_pkg::PH_ENTRY;
              end else if (pending == svs_pkg::REQ_ERROR) begin
                if (illegal != 8'hFF)
                  illegal = illegal + 8'd1;
                else
                  capped_takes++;
              end
              pending = svs_pkg::REQ_NONE;
            end
            svs_pkg::MS_INIT: begin
              r.check_performed = svs_pkg::CHK_INIT_PHASE + 3'(phase);
              if (b.check_ok) begin
                case (phase)
                  svs_pkg::PH_ENTRY: begin
                    wd_active = 1'b1;
                    refresh_cnt = wd_period;
                    wait_cnt = 16'(short_w);
                    phase = svs_pkg::PH_REFRESHES;
                    retries = '0;
                  end
                  svs_pkg::PH_REFRESHES: begin
                    retries = '0;
                    wait_cnt = 16'(b.required_refreshes) * 16'(wd_period);
                    phase = svs_pkg::PH_FAULT_CNT;
                  end
                  svs_pkg::PH_FAULT_CNT: begin
                    phase = svs_pkg::PH_SAFETY;
                    wait_cnt = 16'(short_w);
                  end
                  default: begin
                    retries = '0;
                    mstate = svs_pkg::MS_RUN;
                    phase = svs_pkg::PH_ENTRY;
                    wait_cnt = 16'(short_w);
                  end
                endcase
              end else begin
                was_phase = phase;
                gave_up = (retries >= svs_pkg::MAX_RETRIES_DEF);
                if (gave_up) begin
                  retries = '0;
                  mstate = svs_pkg::MS_ERR;
                  phase = svs_pkg::PH_ENTRY;
                end else begin
                  retries = retries + 3'd1;
                end
                // The first two phases retry on the very next tick.
                if (gave_up || was_phase == svs_pkg::PH_FAULT_CNT ||
                    was_phase == svs_pkg::PH_SAFETY)
                  wait_cnt = 16'(short_w);
              end
            end
            svs_pkg::MS_RUN: begin
              wait_cnt = 16'(long_w);
              if (ignition_chk)
                r.check_performed = svs_pkg::CHK_IGNITION;
            end
            default: wait_cnt = 16'(long_w);
          endcase
        end
      end
      r.machine_state = mstate;
      r.init_phase = phase;
      r.illegal_requests = illegal;
      expected_results.push_back(r);
    endfunction

    function void check_beat(logic [svs_pkg::OUT_TDATA_W-1:0] data);
      svs_pkg::result_t got;
      svs_pkg::result_t want;
      got.request_status   = data[1:0];
      got.watchdog_refresh = data[2];
      got.check_performed  = data[5:3];
      got.machine_state    = data[7:6];
      got.init_phase       = data[9:8];
      got.illegal_requests = data[17:10];
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %h at %0t", data, $realtime);
        return;
      end
      want = expected_results.pop_front();
      if (got.request_status !== want.request_status ||
          got.watchdog_refresh !== want.watchdog_refresh ||
          got.check_performed !== want.check_performed ||
          got.machine_state !== want.machine_state ||
          got.init_phase !== want.init_phase ||
          got.illegal_requests !== want.illegal_requests ||
          data[svs_pkg::OUT_TDATA_W-1:18] !== '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch (expected/actual): status %0d/%0d refresh %0d/%0d ",
                   checked, want.request_status, got.request_status,
                   want.watchdog_refresh, got.watchdog_refresh,
                   "check %0d/%0d state %0d/%0d phase %0d/%0d illegal %0d/%0d fill %h",
                   want.check_performed, got.check_performed,
                   want.machine_state, got.machine_state, want.init_phase, got.init_phase,
                   want.illegal_requests, got.illegal_requests,
                   data[svs_pkg::OUT_TDATA_W-1:18]);
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [svs_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [svs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [svs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [svs_pkg::CFG_DATA_W-1:0]  cfg_data;

  sequencer_scoreboard sb = new();

  // Stimulus controls shared between the sender and the receiver.
  bit calm;          // no idling on either side
  bit hold_off_req;  // asks the receiver for one long stall
  bit kill_ok;       // a watchdog refresh may be reported as failed
  bit aim_error;     // initialization is driven into the error state

  supervisor_init_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // A hard limit on simulated time, far above the slowest legal run.
  initial begin
    #4_000_000;
    $display("Timeout with %0d results still expected.", sb.expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Every beat that the block hands over is checked at the edge where it is taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_beat(out_tdata);
  end

  // Receiver. It stalls in random bursts, except in the calm tail of the run.
  // When asked, it stalls once for a long stretch so that both pipeline
  // registers fill up and in_tready has to drop while beats keep coming.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_off_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic svs_pkg::in_item_t beat(logic op, logic [1:0] kind, logic ok,
                                             logic [7:0] rr, logic rok);
    svs_pkg::in_item_t b;
    b.operation = op;
    b.request_kind = kind;
    b.check_ok = ok;
    b.required_refreshes = rr;
    b.refresh_ok = rok;
    return b;
  endfunction

  // Offers one beat and returns at the edge where it is accepted. tvalid is
  // left high so that a following beat can go out back to back.
  task automatic send_beat(input svs_pkg::in_item_t b);
    in_tvalid <= 1'b1;
    in_tuser  <= b.operation;
    in_tdata  <= {4'b0, b.refresh_ok, b.required_refreshes, b.check_ok, b.request_kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_beat(b);
  endtask

  task automatic write_reg(input logic [svs_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Waits until the block owes nothing, lets its two-stage pipeline empty,
  // then rewrites all four registers.
  task automatic settle_and_program(input logic [7:0] period, input logic [7:0] short_wait,
                                    input logic [7:0] long_wait, input logic ignition);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(svs_pkg::CFG_WATCHDOG_PERIOD, period);
    write_reg(svs_pkg::CFG_SHORT_WAIT, short_wait);
    write_reg(svs_pkg::CFG_LONG_WAIT, long_wait);
    write_reg(svs_pkg::CFG_USE_IGNITION, {7'b0, ignition});
    cfg_valid <= 1'b0;
  endtask

  // Random beats shaped by the model's current state, so that the sequencer
  // gets through its phases instead of idling in one of them.
  task automatic run_phase(input stim_mode_t mode, input int n_items);
    svs_pkg::in_item_t b;
    int                sent;
    int                pick;
    bit                more;
    sent = 0;
    more = 1'b1;
    while (more) begin
      if (!calm && !hold_off_req && $urandom_range(0, 4) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      b = beat(svs_pkg::OP_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 19);
      if (mode == SATURATE) begin
        // With nothing latched, mostly an error request and sometimes an illegal
        // kind. With a request latched, mostly a tick that takes it, and now and
        // then an init or other request that sees it pending or an error request.
        if (sb.pending == svs_pkg::REQ_NONE) begin
          b.operation = svs_pkg::OP_REQUEST;
          if (pick < 17)
            b.request_kind = svs_pkg::KIND_ERROR;
          else
            b.request_kind = (pick == 17) ? KIND_OTHER : KIND_SPARE;
        end else if (pick >= 16) begin
          b.operation = svs_pkg::OP_REQUEST;
          if (pick == 16)
            b.request_kind = svs_pkg::KIND_INIT;
          else if (pick == 17)
            b.request_kind = KIND_OTHER;
          else
            b.request_kind = svs_pkg::KIND_ERROR;
        end
      end else if (mode == INIT_WALK && sb.mstate == svs_pkg::MS_UNINIT) begin
        if (sb.pending == svs_pkg::REQ_NONE) begin
          b.operation = svs_pkg::OP_REQUEST;
          b.request_kind = svs_pkg::KIND_INIT;
        end
      end else if ($urandom_range(0, 4) == 0) begin
        // An error request stays latched for good once the sequencer has left
        // uninitialized, which hides the already-initialized status; keep it rare.
        b.operation = svs_pkg::OP_REQUEST;
        if (b.request_kind == svs_pkg::KIND_ERROR &&
            (mode == INIT_WALK || $urandom_range(0, 7) != 0))
          b.request_kind = svs_pkg::KIND_INIT;
      end
      if (sb.mstate == svs_pkg::MS_INIT) begin
        // Fail phases often enough to see retries; at the retry limit the run's
        // chosen path decides between running and error.
        if (sb.retries < svs_pkg::MAX_RETRIES_DEF)
          b.check_ok = ($urandom_range(0, 9) >= 4);
        else
          b.check_ok = !aim_error;
        if (sb.phase == svs_pkg::PH_REFRESHES)
          b.required_refreshes =
            8'($urandom_range(0, 40 / (sb.wd_period == 0 ? 1 : sb.wd_period)));
      end
      // A failed refresh stops the watchdog for good, so it is saved for the end.
      if (sb.wd_active && sb.refresh_cnt == 8'd1 && !kill_ok)
        b.refresh_ok = 1'b1;
      send_beat(b);
      sent++;
      case (mode)
        SATURATE:  more = sent < n_items || sb.illegal != 8'hFF || sb.capped_takes < 3 ||
                          sb.pending != svs_pkg::REQ_NONE;
        INIT_WALK: more = sb.mstate == svs_pkg::MS_UNINIT || sb.mstate == svs_pkg::MS_INIT;
        default:   more = sent < n_items;
      endcase
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= svs_pkg::OP_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= svs_pkg::CFG_WATCHDOG_PERIOD;
    cfg_data  <= '0;
    aim_error = ($urandom_range(0, 2) == 0);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset configuration. Ticks with nothing latched
    // do nothing, whatever their fields hold.
    send_beat(beat(svs_pkg::OP_TICK, svs_pkg::KIND_INIT, 1'b0, 8'h00, 1'b0));
    send_beat(beat(svs_pkg::OP_TICK, KIND_SPARE, 1'b1, 8'hFF, 1'b1));
    // Both other kinds are illegal and are not latched.
    send_beat(beat(svs_pkg::OP_REQUEST, KIND_OTHER, 1'b0, 8'h00, 1'b0));
    send_beat(beat(svs_pkg::OP_REQUEST, KIND_SPARE, 1'b1, 8'hFF, 1'b1));
    // An error request is latched; later init and other requests see it pending.
    send_beat(beat(svs_pkg::OP_REQUEST, svs_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b0));
    send_beat(beat(svs_pkg::OP_REQUEST, svs_pkg::KIND_INIT, 1'b1, 8'h55, 1'b0));
    send_beat(beat(svs_pkg::OP_REQUEST, KIND_SPARE, 1'b0, 8'hAA, 1'b1));
    // An error request always wins, even over one already latched.
    send_beat(beat(svs_pkg::OP_REQUEST, svs_pkg::KIND_ERROR, 1'b1, 8'hFF, 1'b1));
    // Taking an error request while uninitialized counts an illegal request.
    send_beat(beat(svs_pkg::OP_TICK, svs_pkg::KIND_ERROR, 1'b1, 8'h01, 1'b1));
    send_beat(beat(svs_pkg::OP_TICK, svs_pkg::KIND_INIT, 1'b0, 8'h80, 1'b0));
    // An accepted init request is displaced by a later error request.
    send_beat(beat(svs_pkg::OP_REQUEST, svs_pkg::KIND_INIT, 1'b0, 8'h00, 1'b0));
    send_beat(beat(svs_pkg::OP_REQUEST, svs_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b0));
    send_beat(beat(svs_pkg::OP_TICK, KIND_OTHER, 1'b0, 8'h7F, 1'b1));

    // Drive the illegal-request count into saturation and a little past it.
    run_phase(SATURATE, 500);

    // One pass through initialization with small waits and random failures.
    settle_and_program(8'($urandom_range(1, 6)), 8'($urandom_range(0, 3)),
                       8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
    run_phase(INIT_WALK, 0);

    // Running (or error) under the largest settings, then the smallest ones:
    // a zero long wait steps the machine on every tick.
    settle_and_program(8'd255, 8'd255, 8'd255, 1'b1);
    run_phase(LATE, 200);
    settle_and_program(8'd1, 8'd0, 8'd0, 1'b0);
    run_phase(LATE, 160);

    // Random settings with one long receiver stall so the input side backs up.
    settle_and_program(8'($urandom_range(1, 12)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 8)), 1'($urandom_range(0, 1)));
    hold_off_req = 1'b1;
    run_phase(LATE, 120);

    // Calm tail: no idling. Either the watchdog period drops to zero, which stops
    // refreshing at the next reload, or a refresh may fail and stop it.
    settle_and_program($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 4)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 4)),
                       1'($urandom_range(0, 1)));
    calm = 1'b1;
    kill_ok = 1'b1;
    run_phase(LATE, 120);

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Drove %0d request beats and %0d tick beats; %0d result beats checked.",
             sb.n_requests, sb.n_ticks, sb.checked);
    $display("Ended in state %0d with %0d illegal requests and %0d watchdog refreshes.",
             sb.mstate, sb.illegal, sb.n_strobes);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches in total.", sb.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
